>>> hw/rtl/ats_pkg.sv
// Shared types, constants and helper functions of the assembler token scanner.
// Depends on nothing; all but ats_ram and the interfaces use its scoped names.
package ats_pkg;

    localparam int KW_COUNT = 62;
    localparam int KEY_CHARS = 7;
    localparam int POS_W = 6;

    typedef enum logic [3:0] {
        K_IDENT   = 4'd0,
        K_KEYWORD = 4'd1,
        K_NUMBER  = 4'd2,
        K_STRING  = 4'd3,
        K_PLUS    = 4'd4,
        K_MINUS   = 4'd5,
        K_COLON   = 4'd6,
        K_COMMA   = 4'd7,
        K_LBRAC   = 4'd8,
        K_RBRAC   = 4'd9,
        K_BAD     = 4'd10,
        K_END     = 4'd11
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_DEC     = 4'd2,
        M_ZERO    = 4'd3,
        M_HEXPRE  = 4'd4,
        M_HEX     = 4'd5,
        M_BINPRE  = 4'd6,
        M_BIN     = 4'd7,
        M_OCT     = 4'd8,
        M_STR     = 4'd9,
        M_COMMENT = 4'd10
    } t_mode;

    typedef enum logic [1:0] {
        S_SCAN = 2'd0,
        S_RUN  = 2'd1,
        S_PEND = 2'd2
    } t_state;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] value;
        logic        bad;
    } t_item;

    // What one accepted byte produces: a first token (single or a text run) and
    // possibly a second single token from the rescanned byte.
    typedef struct packed {
        t_item             first;
        logic              first_run;
        logic [POS_W-1:0]  run_len;
        t_item             second;
    } t_step;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

    // Keywords right-justified: the last character sits in the low byte.
    localparam logic [8*KEY_CHARS-1:0] KW_TABLE [KW_COUNT] = '{
        "al", "cl", "dl", "bl", "ah", "ch", "dh", "bh",
        "ax", "cx", "dx", "bx", "sp", "bp", "si", "di",
        "eax", "ecx", "edx", "ebx", "esp", "ebp", "esi", "edi",
        "mov", "cmp", "sub", "add", "and", "or", "lea",
        "call", "int", "imul", "idiv", "neg",
        "inc", "dec", "jmp", "je", "jne", "jg", "jl", "jge", "jle", "jna",
        "sete", "setne", "setg", "setge", "setl", "setle",
        "push", "pop", "ret",
        "section", "global", "equ", "times", "db", "dw", "dd"
    };

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                   b == "_" || b == "@" || b == ".";
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        is_dec = b >= "0" && b <= "9";
    endfunction

    // Returns {valid, digit value}.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, b[3:0]};
        end else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        hex_val = r;
    endfunction

    // Returns {hit, index}. Stored characters are never zero, so equal
    // right-justified keys also have equal lengths.
    function automatic logic [6:0] kw_lookup(input logic [8*KEY_CHARS-1:0] key,
                                             input logic [POS_W-1:0] count);
        logic [6:0] r;
        r = '0;
        if (count != '0 && count <= POS_W'(KEY_CHARS)) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                if (KW_TABLE[i] == key) begin
                    r = {1'b1, 6'(i)};
                end
            end
        end
        kw_lookup = r;
    endfunction

    function automatic t_item mk_item(input t_kind k, input logic [31:0] v,
                                      input logic bad);
        t_item it;
        it.valid = 1'b1;
        it.kind  = k;
        it.value = v;
        it.bad   = bad;
        mk_item  = it;
    endfunction

endpackage

>>> hw/rtl/ats_byte_if.sv
// Input channel of the token scanner: one source byte per request.
// Depends on nothing.
interface ats_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

>>> hw/rtl/ats_tok_if.sv
// Output channel of the token scanner: one token item per request.
// Depends on nothing.
interface ats_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_value;
    logic [7:0]  text_char;
    logic [5:0]  text_pos;
    logic        last_of_run;
    logic [15:0] line_number;
    logic        bad_number;
    logic [15:0] error_total;

    modport source (output valid, output token_kind, output token_value,
                    output text_char, output text_pos, output last_of_run,
                    output line_number, output bad_number, output error_total,
                    input ready);
    modport sink (input valid, input token_kind, input token_value,
                  input text_char, input text_pos, input last_of_run,
                  input line_number, input bad_number, input error_total,
                  output ready);
endinterface

>>> hw/rtl/ats_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/ats_scan.sv
// Character classifier and scan-mode registers of the token scanner.
// Depends on ats_pkg; drives writes into the text store owned by the top level.
module ats_scan #(
    parameter int NAME_MAX = 32,
    parameter int STRING_MAX = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic [3:0]    i_max_dec,
    output ats_pkg::t_step o_step,
    output ats_pkg::t_wr  o_wr,
    output logic [15:0]   o_line,
    output logic [15:0]   o_bad,
    output logic [15:0]   o_bad_next
);
    ats_pkg::t_mode r_mode, n_mode;
    logic [5:0]  r_text_count, n_text_count;
    logic [15:0] r_real_len, n_real_len;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_digits, n_digits;
    logic [15:0] r_line, n_line;
    logic [15:0] r_bad, n_bad;
    logic [55:0] r_key, n_key;

    ats_pkg::t_step v_step;
    ats_pkg::t_wr   v_wr;
    ats_pkg::t_item v_it;
    logic           v_idle;
    logic [6:0]     v_kw;
    logic [4:0]     v_hex;
    logic [5:0]     v_limit;

    always_comb begin
        n_mode       = r_mode;
        n_text_count = r_text_count;
        n_real_len   = r_real_len;
        n_acc        = r_acc;
        n_digits     = r_digits;
        n_line       = r_line;
        n_bad        = r_bad;
        n_key        = r_key;
        v_step       = '0;
        v_wr         = '0;
        v_it         = '0;
        v_idle       = 1'b0;
        v_kw         = ats_pkg::kw_lookup(r_key, r_text_count);
        v_hex        = ats_pkg::hex_val(i_byte);
        v_limit      = (r_mode == ats_pkg::M_STR) ? 6'(STRING_MAX) : 6'(NAME_MAX);

        if (i_byte == ats_pkg::CH_LF && r_line != 16'hFFFF) begin
            n_line = r_line + 16'd1;
        end

        case (r_mode)
            ats_pkg::M_IDENT, ats_pkg::M_STR: begin
                if (r_mode == ats_pkg::M_STR && i_byte == 8'h00) begin
                    v_step.first = ats_pkg::mk_item(ats_pkg::K_END, '0, 1'b0);
                    n_mode = ats_pkg::M_IDLE;
                end else if ((r_mode == ats_pkg::M_STR && i_byte != ats_pkg::CH_QUOTE) ||
                             (r_mode == ats_pkg::M_IDENT &&
                              (ats_pkg::is_alpha(i_byte) || ats_pkg::is_dec(i_byte)))) begin
                    if (r_real_len != 16'hFFFF) begin
                        n_real_len = r_real_len + 16'd1;
                    end
                    if (r_text_count < v_limit) begin
                        v_wr.en   = 1'b1;
                        v_wr.addr = r_text_count;
                        v_wr.data = i_byte;
                        n_text_count = r_text_count + 6'd1;
                        if (r_text_count < 6'(ats_pkg::KEY_CHARS)) begin
                            n_key = {r_key[47:0], i_byte};
                        end
                    end
                end else begin
                    // Token complete: ident ends on any other byte, string on the quote.
                    if (r_mode == ats_pkg::M_IDENT && v_kw[6]) begin
                        v_step.first = ats_pkg::mk_item(ats_pkg::K_KEYWORD,
                                                        {26'd0, v_kw[5:0]}, 1'b0);
                    end else begin
                        v_step.first = ats_pkg::mk_item(
                            (r_mode == ats_pkg::M_IDENT) ? ats_pkg::K_IDENT : ats_pkg::K_STRING,
                            {16'd0, r_real_len}, 1'b0);
                    end
                    v_step.first_run = (r_text_count != '0);
                    v_step.run_len   = r_text_count;
                    n_mode = ats_pkg::M_IDLE;
                    v_idle = (r_mode == ats_pkg::M_IDENT);
                end
            end
            ats_pkg::M_DEC: begin
                if (ats_pkg::is_dec(i_byte)) begin
                    if (r_digits < i_max_dec) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {28'd0, i_byte[3:0]};
                        n_digits = r_digits + 4'd1;
                    end
                end else begin
                    v_step.first = ats_pkg::mk_item(ats_pkg::K_NUMBER, r_acc, 1'b0);
                    n_mode = ats_pkg::M_IDLE;
                    v_idle = 1'b1;
                end
            end
            ats_pkg::M_ZERO: begin
                if (i_byte == "x" || i_byte == "X") begin
                    n_mode = ats_pkg::M_HEXPRE;
                end else if (i_byte == "b" || i_byte == "B") begin
                    n_mode = ats_pkg::M_BINPRE;
                end else if (i_byte >= "0" && i_byte <= "7") begin
                    n_acc  = {29'd0, i_byte[2:0]};
                    n_mode = ats_pkg::M_OCT;
                end else begin
                    v_step.first = ats_pkg::mk_item(ats_pkg::K_NUMBER, '0, 1'b0);
                    n_mode = ats_pkg::M_IDLE;
                    v_idle = 1'b1;
                end
            end
            ats_pkg::M_HEXPRE, ats_pkg::M_HEX: begin
                if (v_hex[4]) begin
                    n_acc  = {r_acc[27:0], v_hex[3:0]};
                    n_mode = ats_pkg::M_HEX;
                end else begin
                    v_step.first = ats_pkg::mk_item(ats_pkg::K_NUMBER, r_acc,
                                                    r_mode == ats_pkg::M_HEXPRE);
                    n_mode = ats_pkg::M_IDLE;
                    v_idle = 1'b1;
                end
            end
            ats_pkg::M_BINPRE, ats_pkg::M_BIN: begin
                if (i_byte == "0" || i_byte == "1") begin
                    n_acc  = {r_acc[30:0], i_byte[0]};
                    n_mode = ats_pkg::M_BIN;
                end else begin
                    v_step.first = ats_pkg::mk_item(ats_pkg::K_NUMBER, r_acc,
                                                    r_mode == ats_pkg::M_BINPRE);
                    n_mode = ats_pkg::M_IDLE;
                    v_idle = 1'b1;
                end
            end
            ats_pkg::M_OCT: begin
                if (i_byte >= "0" && i_byte <= "7") begin
                    n_acc = {r_acc[28:0], i_byte[2:0]};
                end else begin
                    v_step.first = ats_pkg::mk_item(ats_pkg::K_NUMBER, r_acc, 1'b0);
                    n_mode = ats_pkg::M_IDLE;
                    v_idle = 1'b1;
                end
            end
            ats_pkg::M_COMMENT: begin
                if (i_byte == ats_pkg::CH_LF) begin
                    n_mode = ats_pkg::M_IDLE;
                end else if (i_byte == 8'h00) begin
                    v_step.first = ats_pkg::mk_item(ats_pkg::K_END, '0, 1'b0);
                    n_mode = ats_pkg::M_IDLE;
                end
            end
            default: begin
                n_mode = ats_pkg::M_IDLE;
                v_idle = 1'b1;
            end
        endcase

        // Byte seen between tokens, either fresh or rescanned after a terminator.
        if (v_idle) begin
            case (i_byte)
                8'h00: v_it = ats_pkg::mk_item(ats_pkg::K_END, '0, 1'b0);
                ats_pkg::CH_SPACE, ats_pkg::CH_LF, ats_pkg::CH_TAB: v_it = '0;
                "+": v_it = ats_pkg::mk_item(ats_pkg::K_PLUS, '0, 1'b0);
                "-": v_it = ats_pkg::mk_item(ats_pkg::K_MINUS, '0, 1'b0);
                ":": v_it = ats_pkg::mk_item(ats_pkg::K_COLON, '0, 1'b0);
                ",": v_it = ats_pkg::mk_item(ats_pkg::K_COMMA, '0, 1'b0);
                "[": v_it = ats_pkg::mk_item(ats_pkg::K_LBRAC, '0, 1'b0);
                "]": v_it = ats_pkg::mk_item(ats_pkg::K_RBRAC, '0, 1'b0);
                ats_pkg::CH_SEMI: n_mode = ats_pkg::M_COMMENT;
                ats_pkg::CH_QUOTE: begin
                    n_text_count = '0;
                    n_real_len   = '0;
                    n_mode       = ats_pkg::M_STR;
                end
                ats_pkg::CH_ZERO: begin
                    n_acc    = '0;
                    n_digits = '0;
                    n_mode   = ats_pkg::M_ZERO;
                end
                default: begin
                    if (ats_pkg::is_alpha(i_byte)) begin
                        v_wr.en      = 1'b1;
                        v_wr.addr    = '0;
                        v_wr.data    = i_byte;
                        n_text_count = 6'd1;
                        n_real_len   = 16'd1;
                        n_key        = {48'd0, i_byte};
                        n_mode       = ats_pkg::M_IDENT;
                    end else if (ats_pkg::is_dec(i_byte)) begin
                        if (i_max_dec != '0) begin
                            n_acc    = {28'd0, i_byte[3:0]};
                            n_digits = 4'd1;
                        end else begin
                            n_acc    = '0;
                            n_digits = '0;
                        end
                        n_mode = ats_pkg::M_DEC;
                    end else begin
                        if (r_bad != 16'hFFFF) begin
                            n_bad = r_bad + 16'd1;
                        end
                        v_it = ats_pkg::mk_item(ats_pkg::K_BAD, '0, 1'b0);
                    end
                end
            endcase
            if (v_step.first.valid) begin
                v_step.second = v_it;
            end else begin
                v_step.first = v_it;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ats_pkg::M_IDLE;
            r_text_count <= '0;
            r_real_len   <= '0;
            r_acc        <= '0;
            r_digits     <= '0;
            r_line       <= '0;
            r_bad        <= '0;
            r_key        <= '0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_text_count <= n_text_count;
            r_real_len   <= n_real_len;
            r_acc        <= n_acc;
            r_digits     <= n_digits;
            r_line       <= n_line;
            r_bad        <= n_bad;
            r_key        <= n_key;
        end
    end

    assign o_step     = v_step;
    assign o_wr       = v_wr;
    assign o_line     = r_line;
    assign o_bad      = r_bad;
    assign o_bad_next = n_bad;
endmodule

>>> hw/rtl/assembler_token_scanner_top.sv
// Top level of the assembler token scanner: request channels, APB register,
// output sequencer and text store. Depends on ats_pkg, ats_byte_if, ats_tok_if,
// ats_ram and ats_scan.
//
//   channel   direction  carries
//   i_byte    in         one source byte per request (0 ends the text)
//   o_tok     out        one token item per request; text tokens as a run
//   APB       in/out     register 0: max_dec_digits (4 bits, reset 10)
//
// A byte is classified and absorbed in the cycle it is accepted. A byte that
// completes an identifier or string keeps the input closed while its stored
// characters are read from the text store, one per cycle unless stalled (the
// store's single read port sets this), and for a rescanned token after them.
// A byte is only accepted when the output register is empty or being taken,
// so a stall on the output holds the input back. Reset is synchronous and
// needs no clearing pass: the text store is only read where it was written.
module assembler_token_scanner_top #(
    parameter int NAME_MAX = 32,
    parameter int STRING_MAX = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ats_byte_if.sink     i_byte,
    ats_tok_if.source    o_tok,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    // The store holds as many characters as the longer text limit.
    localparam int STORE_DEPTH = (NAME_MAX > STRING_MAX) ? NAME_MAX : STRING_MAX;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam logic REG_MAX_DEC = 1'b0;

    // Configuration register: written at the access phase of an APB write.
    logic [3:0] r_max_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dec <= 4'd10;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_DEC) begin
            r_max_dec <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_DEC) ? {28'd0, r_max_dec} : '0;

    // Scanner core: consumes the accepted byte and reports what it yields.
    ats_pkg::t_step scan_step;
    ats_pkg::t_wr   scan_wr;
    logic [15:0]    scan_line;
    logic [15:0]    scan_bad;
    logic [15:0]    scan_bad_next;
    logic           in_accept;

    ats_scan #(
        .NAME_MAX   (NAME_MAX),
        .STRING_MAX (STRING_MAX)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_byte     (i_byte.in_byte),
        .i_max_dec  (r_max_dec),
        .o_step     (scan_step),
        .o_wr       (scan_wr),
        .o_line     (scan_line),
        .o_bad      (scan_bad),
        .o_bad_next (scan_bad_next)
    );

    // Text store: written while identifiers and strings are collected, read
    // back one character per cycle while a run is sent and the output is free.
    logic             ram_re;
    logic [5:0]       ram_raddr;
    logic [7:0]       ram_rdata;

    ats_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (scan_wr.en && in_accept),
        .i_waddr (scan_wr.addr[ADDR_W-1:0]),
        .i_wdata (scan_wr.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Output sequencer state.
    ats_pkg::t_state r_state, n_state;
    ats_pkg::t_item  r_pend;
    ats_pkg::t_item  r_run;
    logic [5:0]      r_run_len;
    logic [5:0]      r_pos;
    logic [15:0]     r_run_err;

    // Output register.
    logic            r_ov;
    ats_pkg::t_kind  r_kind;
    logic [31:0]     r_value;
    logic [7:0]      r_char;
    logic [5:0]      r_tpos;
    logic            r_last;
    logic            r_badnum;
    logic [15:0]     r_err;

    logic out_free;
    logic run_last;
    logic load_first;
    logic load_run;
    logic load_pend;
    logic start_run;

    assign out_free = !r_ov || o_tok.ready;
    assign run_last = (r_pos + 6'd1) == r_run_len;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ats_pkg::S_SCAN: begin
                if (in_accept && scan_step.first.valid) begin
                    if (scan_step.first_run) begin
                        n_state = ats_pkg::S_RUN;
                    end else if (scan_step.second.valid) begin
                        n_state = ats_pkg::S_PEND;
                    end
                end
            end
            ats_pkg::S_RUN: begin
                if (out_free && run_last) begin
                    n_state = r_pend.valid ? ats_pkg::S_PEND : ats_pkg::S_SCAN;
                end
            end
            ats_pkg::S_PEND: begin
                if (out_free) begin
                    n_state = ats_pkg::S_SCAN;
                end
            end
            default: n_state = ats_pkg::S_SCAN;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        in_accept  = 1'b0;
        load_first = 1'b0;
        load_run   = 1'b0;
        load_pend  = 1'b0;
        start_run  = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        case (r_state)
            ats_pkg::S_SCAN: begin
                in_accept = i_byte.valid && out_free;
                if (in_accept && scan_step.first.valid) begin
                    if (scan_step.first_run) begin
                        start_run = 1'b1;
                        ram_re    = 1'b1;
                    end else begin
                        load_first = 1'b1;
                    end
                end
            end
            ats_pkg::S_RUN: begin
                if (out_free) begin
                    load_run = 1'b1;
                    if (!run_last) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_pos + 6'd1;
                    end
                end
            end
            ats_pkg::S_PEND: begin
                load_pend = out_free;
            end
            default: begin
                in_accept = 1'b0;
            end
        endcase
    end

    assign i_byte.ready = (r_state == ats_pkg::S_SCAN) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ats_pkg::S_SCAN;
            r_ov        <= 1'b0;
            r_pend.valid <= 1'b0;
            r_err       <= '0;
        end else begin
            r_state <= n_state;
            if (load_first || load_run || load_pend) begin
                r_ov <= 1'b1;
            end else if (o_tok.ready) begin
                r_ov <= 1'b0;
            end
            if (start_run || load_first) begin
                r_pend.valid <= scan_step.second.valid;
            end else if (load_pend) begin
                r_pend.valid <= 1'b0;
            end
            // A bad character counts from its own item on; a token that it
            // ends still shows the count from before it.
            if (load_first) begin
                r_err <= (scan_step.first.kind == ats_pkg::K_BAD) ? scan_bad_next : scan_bad;
            end else if (load_run) begin
                r_err <= r_run_err;
            end else if (load_pend) begin
                r_err <= scan_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_run || load_first) begin
            r_pend.kind  <= scan_step.second.kind;
            r_pend.value <= scan_step.second.value;
            r_pend.bad   <= scan_step.second.bad;
        end
        if (start_run) begin
            r_run     <= scan_step.first;
            r_run_len <= scan_step.run_len;
            r_run_err <= scan_bad;
            r_pos     <= '0;
        end else if (load_run && !run_last) begin
            r_pos <= r_pos + 6'd1;
        end
        if (load_first) begin
            r_kind   <= scan_step.first.kind;
            r_value  <= scan_step.first.value;
            r_char   <= '0;
            r_tpos   <= '0;
            r_last   <= 1'b1;
            r_badnum <= scan_step.first.bad;
        end else if (load_run) begin
            r_kind   <= r_run.kind;
            r_value  <= r_run.value;
            r_char   <= ram_rdata;
            r_tpos   <= r_pos;
            r_last   <= run_last;
            r_badnum <= 1'b0;
        end else if (load_pend) begin
            r_kind   <= r_pend.kind;
            r_value  <= r_pend.value;
            r_char   <= '0;
            r_tpos   <= '0;
            r_last   <= 1'b1;
            r_badnum <= r_pend.bad;
        end
    end

    // The line count is only updated by an accepted byte, which waits until
    // all items of the previous byte are gone, and it grows before any item of
    // that byte, so it is shown directly. The error count is held per item.
    assign o_tok.valid       = r_ov;
    assign o_tok.token_kind  = r_kind;
    assign o_tok.token_value = r_value;
    assign o_tok.text_char   = r_char;
    assign o_tok.text_pos    = r_tpos;
    assign o_tok.last_of_run = r_last;
    assign o_tok.line_number = scan_line;
    assign o_tok.bad_number  = r_badnum;
    assign o_tok.error_total = r_err;
endmodule

>>> hw/rtl/ats_chk.sv
// Port-level checker of the assembler token scanner, bound to the top level.
// Depends on ats_pkg and on the top level's channel ports.
module ats_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_kind,
    input logic [31:0] i_value,
    input logic [5:0]  i_pos,
    input logic        i_last,
    input logic [15:0] i_line,
    input logic [15:0] i_err
);
    logic run_kind;
    assign run_kind = i_kind == ats_pkg::K_IDENT || i_kind == ats_pkg::K_KEYWORD ||
                      i_kind == ats_pkg::K_STRING;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value) && $stable(i_kind))
        else $error("stalled token changed");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("byte accepted while output stalled");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !run_kind |-> i_last && i_pos == 6'd0)
        else $error("single token not marked last");

    a_run_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> run_kind)
        else $error("non-text token continued");

    a_counts_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_err >= $past(i_err) && i_line >= $past(i_line))
        else $error("line or error count decreased");
endmodule

bind assembler_token_scanner_top ats_chk u_ats_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_kind      (o_tok.token_kind),
    .i_value     (o_tok.token_value),
    .i_pos       (o_tok.text_pos),
    .i_last      (o_tok.last_of_run),
    .i_line      (o_tok.line_number),
    .i_err       (o_tok.error_total)
);

>>> dv/tb_assembler_token_scanner_top.sv
// Self-checking testbench for assembler_token_scanner_top: byte requests in, token
// requests out, with an internal predictor of the scanner. Depends on ats_pkg,
// ats_byte_if, ats_tok_if and the scanner top level.
module tb_assembler_token_scanner_top;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [7:0]  ch;
        logic [5:0]  pos;
        logic        last;
        logic [15:0] lines;
        logic        bad;
        logic [15:0] errs;
    } tok_t;

    localparam int TEXT_LIMIT = 32;   // both identifier and string store sizes
    localparam int DRAIN_CYCLES = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    ats_byte_if byte_ch ();
    ats_tok_if  tok_ch ();

    assembler_token_scanner_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_tok   (tok_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Source bytes waiting to be sent, and tokens the scanner still owes us.
    logic [7:0] src_bytes[$];
    tok_t       owed_tokens[$];
    int         mismatches = 0;
    bit         quiet = 0;          // no idling on either side when set
    bit         long_hold = 0;      // receiver held off by its own process

    // Scanner state as the predictor sees it.
    logic [3:0]      dec_limit;
    ats_pkg::t_mode  mode;
    logic [7:0]      text[64];
    int              text_len;
    logic [15:0]     true_len;
    logic [31:0]     acc;
    int              ndigits;
    logic [15:0]     lines_seen;
    logic [15:0]     errs_seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               b == "_" || b == "@" || b == ".";
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "A" && b <= "F") return b - "A" + 10;
        if (b >= "a" && b <= "f") return b - "a" + 10;
        return -1;
    endfunction

    function automatic void owe(ats_pkg::t_kind k, logic [31:0] v, logic [7:0] c, int p,
                                bit last, bit bad);
        tok_t t;
        t.kind  = k;
        t.value = v;
        t.ch    = c;
        t.pos   = p[5:0];
        t.last  = last;
        t.lines = lines_seen;
        t.bad   = bad;
        t.errs  = errs_seen;
        owed_tokens.push_back(t);
    endfunction

    // A text token comes out as one item per stored character, or as a single
    // empty item when nothing was stored.
    function automatic void owe_text(ats_pkg::t_kind k, logic [31:0] v);
        if (text_len == 0) begin
            owe(k, v, 8'd0, 0, 1'b1, 1'b0);
        end else begin
            for (int i = 0; i < text_len; i++)
                owe(k, v, text[i], i, i + 1 == text_len, 1'b0);
        end
    endfunction

    function automatic void store_char(logic [7:0] b);
        if (true_len != 16'hFFFF) true_len++;
        if (text_len < TEXT_LIMIT) begin
            text[text_len] = b;
            text_len++;
        end
    endfunction

    // Lookup runs on the stored (possibly truncated) text.
    function automatic int keyword_of_text();
        logic [8*ats_pkg::KEY_CHARS-1:0] key;
        key = '0;
        if (text_len == 0 || text_len > ats_pkg::KEY_CHARS) return -1;
        for (int i = 0; i < text_len; i++)
            key = {key[8*ats_pkg::KEY_CHARS-9:0], text[i]};
        for (int i = 0; i < ats_pkg::KW_COUNT; i++)
            if (ats_pkg::KW_TABLE[i] == key) return i;
        return -1;
    endfunction

    function automatic void start_token(logic [7:0] b);
        case (b)
            8'd0:     owe(ats_pkg::K_END, 0, 0, 0, 1, 0);
            ats_pkg::CH_SPACE, ats_pkg::CH_LF, ats_pkg::CH_TAB: ;
            "+":      owe(ats_pkg::K_PLUS, 0, 0, 0, 1, 0);
            "-":      owe(ats_pkg::K_MINUS, 0, 0, 0, 1, 0);
            ":":      owe(ats_pkg::K_COLON, 0, 0, 0, 1, 0);
            ",":      owe(ats_pkg::K_COMMA, 0, 0, 0, 1, 0);
            "[":      owe(ats_pkg::K_LBRAC, 0, 0, 0, 1, 0);
            "]":      owe(ats_pkg::K_RBRAC, 0, 0, 0, 1, 0);
            ats_pkg::CH_SEMI:  mode = ats_pkg::M_COMMENT;
            ats_pkg::CH_QUOTE: begin
                text_len = 0;
                true_len = 0;
                mode = ats_pkg::M_STR;
            end
            ats_pkg::CH_ZERO: begin
                acc = 0;
                ndigits = 0;
                mode = ats_pkg::M_ZERO;
            end
            default: begin
                if (is_letter(b)) begin
                    text_len = 0;
                    true_len = 0;
                    store_char(b);
                    mode = ats_pkg::M_IDENT;
                end else if (is_digit(b)) begin
                    acc = 0;
                    ndigits = 0;
                    if (dec_limit != 0) begin
                        acc = b - "0";
                        ndigits = 1;
                    end
                    mode = ats_pkg::M_DEC;
                end else begin
                    if (errs_seen != 16'hFFFF) errs_seen++;
                    owe(ats_pkg::K_BAD, 0, 0, 0, 1, 0);
                end
            end
        endcase
    endfunction

    // Consumes one accepted source byte. A byte that ends an identifier or a
    // number goes round the loop a second time as the start of a new token.
    function automatic void scan_byte(logic [7:0] b);
        bit again;
        int h;
        if (b == ats_pkg::CH_LF && lines_seen != 16'hFFFF) lines_seen++;
        again = 1;
        while (again) begin
            again = 0;
            case (mode)
                ats_pkg::M_IDENT: begin
                    if (is_letter(b) || is_digit(b)) begin
                        store_char(b);
                    end else begin
                        h = keyword_of_text();
                        if (h >= 0) owe_text(ats_pkg::K_KEYWORD, h);
                        else owe_text(ats_pkg::K_IDENT, true_len);
                        mode = ats_pkg::M_IDLE;
                        again = 1;
                    end
                end
                ats_pkg::M_DEC: begin
                    if (is_digit(b)) begin
                        if (ndigits < dec_limit) begin
                            acc = acc * 10 + (b - "0");
                            ndigits++;
                        end
                    end else begin
                        owe(ats_pkg::K_NUMBER, acc, 0, 0, 1, 0);
                        mode = ats_pkg::M_IDLE;
                        again = 1;
                    end
                end
                ats_pkg::M_ZERO: begin
                    if (b == "x" || b == "X") begin
                        mode = ats_pkg::M_HEXPRE;
                    end else if (b == "b" || b == "B") begin
                        mode = ats_pkg::M_BINPRE;
                    end else if (b >= "0" && b <= "7") begin
                        acc = b - "0";
                        mode = ats_pkg::M_OCT;
                    end else begin
                        owe(ats_pkg::K_NUMBER, 0, 0, 0, 1, 0);
                        mode = ats_pkg::M_IDLE;
                        again = 1;
                    end
                end
                ats_pkg::M_HEXPRE, ats_pkg::M_HEX: begin
                    h = hex_digit(b);
                    if (h >= 0) begin
                        acc = acc * 16 + h;
                        mode = ats_pkg::M_HEX;
                    end else begin
                        owe(ats_pkg::K_NUMBER, acc, 0, 0, 1, mode == ats_pkg::M_HEXPRE);
                        mode = ats_pkg::M_IDLE;
                        again = 1;
                    end
                end
                ats_pkg::M_BINPRE, ats_pkg::M_BIN: begin
                    if (b == "0" || b == "1") begin
                        acc = acc * 2 + (b - "0");
                        mode = ats_pkg::M_BIN;
                    end else begin
                        owe(ats_pkg::K_NUMBER, acc, 0, 0, 1, mode == ats_pkg::M_BINPRE);
                        mode = ats_pkg::M_IDLE;
                        again = 1;
                    end
                end
                ats_pkg::M_OCT: begin
                    if (b >= "0" && b <= "7") begin
                        acc = acc * 8 + (b - "0");
                    end else begin
                        owe(ats_pkg::K_NUMBER, acc, 0, 0, 1, 0);
                        mode = ats_pkg::M_IDLE;
                        again = 1;
                    end
                end
                ats_pkg::M_STR: begin
                    if (b == 0) begin
                        owe(ats_pkg::K_END, 0, 0, 0, 1, 0);
                        mode = ats_pkg::M_IDLE;
                    end else if (b == ats_pkg::CH_QUOTE) begin
                        owe_text(ats_pkg::K_STRING, true_len);
                        mode = ats_pkg::M_IDLE;
                    end else begin
                        store_char(b);
                    end
                end
                ats_pkg::M_COMMENT: begin
                    if (b == ats_pkg::CH_LF) begin
                        mode = ats_pkg::M_IDLE;
                    end else if (b == 0) begin
                        owe(ats_pkg::K_END, 0, 0, 0, 1, 0);
                        mode = ats_pkg::M_IDLE;
                    end
                end
                default: begin
                    mode = ats_pkg::M_IDLE;
                    start_token(b);
                end
            endcase
        end
    endfunction

    // -------------------------------------------------------------------
    // Stimulus helpers
    // -------------------------------------------------------------------
    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // One well-formed token (mostly), with random content, and possibly a separator.
    task automatic send_random_token();
        int n;
        logic [7:0] c;
        case ($urandom_range(13))
            0, 1: begin
                // Keyword, right-justified in the table: skip leading zero bytes.
                n = $urandom_range(ats_pkg::KW_COUNT - 1);
                for (int i = ats_pkg::KEY_CHARS - 1; i >= 0; i--)
                    if (ats_pkg::KW_TABLE[n][8*i +: 8] != 0)
                        src_bytes.push_back(ats_pkg::KW_TABLE[n][8*i +: 8]);
            end
            2, 3: begin
                n = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 9);
                src_bytes.push_back(pick("abcdefghijklmnopqrstuvwxyzABCXYZ_@."));
                for (int i = 1; i < n; i++)
                    src_bytes.push_back(pick("abcxyzQRS_@.0123456789"));
            end
            4: begin
                n = $urandom_range(1, 14);
                src_bytes.push_back(pick("123456789"));
                for (int i = 1; i < n; i++) src_bytes.push_back(pick("0123456789"));
            end
            5: begin
                send_text($urandom_range(1) ? "0x" : "0X");
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++) src_bytes.push_back(pick("0123456789abcdefABCDEF"));
            end
            6: begin
                send_text($urandom_range(1) ? "0b" : "0B");
                n = $urandom_range(0, 36);
                for (int i = 0; i < n; i++) src_bytes.push_back(pick("01"));
            end
            7: begin
                n = $urandom_range(0, 13);
                src_bytes.push_back("0");
                for (int i = 0; i < n; i++) src_bytes.push_back(pick("01234567"));
            end
            8: begin
                n = ($urandom_range(5) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
                src_bytes.push_back(ats_pkg::CH_QUOTE);
                for (int i = 0; i < n; i++) begin
                    do c = $urandom_range(1, 255); while (c == ats_pkg::CH_QUOTE);
                    src_bytes.push_back(c);
                end
                src_bytes.push_back(ats_pkg::CH_QUOTE);
            end
            9, 10: src_bytes.push_back(pick("+-:,[]"));
            11: begin
                n = $urandom_range(0, 8);
                src_bytes.push_back(ats_pkg::CH_SEMI);
                for (int i = 0; i < n; i++) begin
                    do c = $urandom_range(1, 255); while (c == ats_pkg::CH_LF);
                    src_bytes.push_back(c);
                end
                src_bytes.push_back(ats_pkg::CH_LF);
            end
            12: begin
                // Noise: anything at all except the end byte.
                src_bytes.push_back($urandom_range(1, 255));
            end
            default: src_bytes.push_back($urandom_range(1) ? 8'h0D : 8'($urandom_range(128, 255)));
        endcase
        case ($urandom_range(5))
            0:       src_bytes.push_back(ats_pkg::CH_SPACE);
            1:       src_bytes.push_back(ats_pkg::CH_TAB);
            2:       src_bytes.push_back(ats_pkg::CH_LF);
            3:       src_bytes.push_back(pick("+-,]"));
            default: ;
        endcase
    endtask

    // Blocks until every byte is taken and every owed token has come, then
    // lets the block settle before a register write.
    task automatic drain();
        do @(negedge i_clk);
        while (src_bytes.size() != 0 || byte_ch.valid || owed_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // The write lands at this edge; only register 0 exists.
        if (addr == 3'd0) dec_limit = data[3:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int start;
        start = src_bytes.size();
        while (src_bytes.size() - start < count) send_random_token();
        src_bytes.push_back(8'd0);   // close the text so the scanner is idle
    endtask

    // -------------------------------------------------------------------
    // Sequence of the run
    // -------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        byte_ch.valid    = 1'b0;
        byte_ch.in_byte  = 8'd0;
        tok_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = 3'd0;
        pwdata           = 32'd0;
        dec_limit        = 4'd10;
        mode             = ats_pkg::M_IDLE;
        text_len         = 0;
        true_len         = 0;
        acc              = 0;
        ndigits          = 0;
        lines_seen       = 0;
        errs_seen        = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: keywords, brackets, prefixes, an empty string and a lone zero.
        send_text("mov eax,[ebx+0x1F]\n\"\"0 0b2 0x");
        src_bytes.push_back(8'd0);   // bad hex prefix ended by the end byte
        send_text("077-99999999999 \"ab");
        src_bytes.push_back(8'd0);   // end inside a string
        drain();

        apb_write(3'd4, 32'd3);      // unmapped index, must be ignored
        apb_write(3'd0, 32'd1);
        send_text("123;x");
        src_bytes.push_back(8'd0);   // end inside a comment
        random_phase(60);
        drain();

        apb_write(3'd0, 32'd0);
        random_phase(60);
        drain();

        apb_write(3'd0, 32'd15);
        random_phase(100);
        drain();

        apb_write(3'd0, 32'd5);
        random_phase(80);
        drain();

        apb_write(3'd0, 32'd10);
        quiet = 1;
        random_phase(80);
        drain();

        if (mismatches == 0) begin
            $display("tb_assembler_token_scanner_top: done, clean");
        end else begin
            $display("tb_assembler_token_scanner_top: done, errors");
        end
        $finish;
    end

    // Long receiver hold-off while the sender keeps offering bytes.
    initial begin
        int hold_cycles;
        wait (i_rst_n);
        repeat (1500) @(posedge i_clk);
        long_hold <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
            @(posedge i_clk);
            hold_cycles++;
        end
        long_hold <= 1'b0;
    end

    initial begin
        #20000000;
        $display("tb_assembler_token_scanner_top: done, errors");
        $finish;
    end

    // -------------------------------------------------------------------
    // Byte driver: presents the queue head, with random bursts of idle.
    // -------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && (!byte_ch.valid || byte_ch.ready)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                byte_ch.valid <= 1'b0;
            end else if (src_bytes.size() != 0) begin
                byte_ch.valid   <= 1'b1;
                byte_ch.in_byte <= src_bytes.pop_front();
                if (!quiet && $urandom_range(9) == 0) send_gap <= $urandom_range(1, 13);
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Every accepted request feeds the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) scan_byte(byte_ch.in_byte);
    end

    // -------------------------------------------------------------------
    // Token receiver: random stall bursts, and the long hold-off.
    // -------------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tok_ch.ready <= 1'b0;
        end else if (long_hold) begin
            tok_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            tok_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(11) == 0) begin
            stall_left <= $urandom_range(0, 12);
            tok_ch.ready <= 1'b0;
        end else begin
            tok_ch.ready <= 1'b1;
        end
    end

    // Monitor: each accepted token request against the oldest owed token.
    always @(posedge i_clk) begin
        tok_t want;
        if (i_rst_n && tok_ch.valid && tok_ch.ready) begin
            if (owed_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d value %0h", tok_ch.token_kind,
                             tok_ch.token_value);
            end else begin
                want = owed_tokens.pop_front();
                if (tok_ch.token_kind !== want.kind || tok_ch.token_value !== want.value ||
                    tok_ch.text_char !== want.ch || tok_ch.text_pos !== want.pos ||
                    tok_ch.last_of_run !== want.last || tok_ch.line_number !== want.lines ||
                    tok_ch.bad_number !== want.bad || tok_ch.error_total !== want.errs) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("token mismatch: expected kind %0d value %0h char %0h pos %0d",
                                 want.kind, want.value, want.ch, want.pos);
                        $display("  expected last %0b line %0d bad %0b errs %0d",
                                 want.last, want.lines, want.bad, want.errs);
                        $display("  got kind %0d value %0h char %0h pos %0d",
                                 tok_ch.token_kind, tok_ch.token_value, tok_ch.text_char,
                                 tok_ch.text_pos);
                        $display("  got last %0b line %0d bad %0b errs %0d",
                                 tok_ch.last_of_run, tok_ch.line_number,
                                 tok_ch.bad_number, tok_ch.error_total);
                    end
                end
            end
        end
    end

endmodule
